FILE: hw/rtl/simulated_binary_crossover_top_defines.svh
// assertion macros for the crossover checker
// needs clk and rst_n in the scope of use
`ifndef SIMULATED_BINARY_CROSSOVER_TOP_DEFINES_SVH
`define SIMULATED_BINARY_CROSSOVER_TOP_DEFINES_SVH

// clocked implication, off during reset
`define SBX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define SBX_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/sbx_pkg.sv
// shared types and constants for the crossover block
// no dependencies
`default_nettype none

package sbx_pkg;

    localparam int GeneW    = 16;
    localparam int EtaW     = 15;
    localparam int BetaW    = 32;
    localparam logic [EtaW-1:0]  EtaReset = 15'd5120;
    localparam logic [BetaW-1:0] BetaOne  = 32'd65536;
    localparam logic [GeneW:0]   GeneMax  = 17'd32768;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_NORM,
        ST_LOG,
        ST_SCALE,
        ST_EXPO,
        ST_SHIFT,
        ST_MUL,
        ST_OUT
    } state_t;

    typedef logic [15:0][30:0] root_tab_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bitv;
        v = val;
        r = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= r + bitv)
            begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
            begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // roots 2^(2^-j) in q1.30, j from 1
    function automatic root_tab_t make_roots();
        root_tab_t   t;
        logic [63:0] root;
        root = isqrt64(64'd1 << 61);
        for (int j = 0; j < 16; j++)
        begin
            t[j] = root[30:0];
            root = isqrt64(root << 30);
        end
        return t;
    endfunction

    localparam root_tab_t Roots = make_roots();

endpackage

`default_nettype wire

FILE: hw/rtl/simulated_binary_crossover_top.sv
// simulated binary crossover over a stream of gene pairs
// depends on sbx_pkg
//
// Each transfer carries one gene pair and gives one child pair. A pair
// without the first mark is accepted, then its product is formed on the
// shared 32x32 multiplier, then sum and clamp go to the output register.
// A first pair recomputes beta on the same multiplier and a shared
// 32-step restoring divider: normalise, log squarings, scale, divide, root
// products and shift, in that order. A draw above one half first goes
// through the divider and then to normalise. A zero draw skips all this.
// A result that waits on the output register holds the next sum and clamp
// step until it is taken. The input is not ready while a pair is in work.
`default_nettype none

module simulated_binary_crossover_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // uniform_draw, parent_a_gene, parent_b_gene
    input  wire logic        s_axis_tuser,  // first_gene
    input  wire logic        s_axis_tlast,  // last_gene
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // child_a_gene, child_b_gene
    output logic             m_axis_tlast,  // last_child
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [sbx_pkg::EtaW-1:0] cfg_data
);
    import sbx_pkg::*;

    state_t            state_reg, state_next;
    logic [EtaW-1:0]   eta_reg;
    logic [BetaW-1:0]  beta_reg, beta_next;
    logic [15:0]       a_reg, a_next, b_reg, b_next;
    logic              last_reg, last_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              phase_reg, phase_next;
    logic [31:0]       quo_reg, quo_next;
    logic [15:0]       rem_reg, rem_next;
    logic [15:0]       dvs_reg, dvs_next;
    logic [31:0]       m_reg, m_next;
    logic [4:0]        n_reg, n_next;
    logic [15:0]       frac_reg, frac_next;
    logic              neg_reg, neg_next;
    logic signed [5:0] ip_reg, ip_next;
    logic [15:0]       f_reg, f_next;
    logic [30:0]       p_reg, p_next;
    logic [47:0]       prod_reg, prod_next;
    logic              dneg_reg, dneg_next;
    logic              ovalid_reg, ovalid_next;
    logic [15:0]       ca_reg, ca_next, cb_reg, cb_next;
    logic              olast_reg, olast_next;

    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_p;
    logic [16:0] trial;
    logic        fits;
    logic [32:0] sq;
    logic [20:0] lmag;
    logic [21:0] eval;
    logic [4:0]  sh;
    logic [31:0] shr;
    logic [16:0] dsum;
    logic [16:0] ddiff;
    logic [15:0] dmag;
    logic signed [50:0] base, spread, sa, sb;
    logic [15:0] u_in;

    assign mul_p = mul_x * mul_y;
    assign trial = {rem_reg, quo_reg[31]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign sq    = mul_p[63:31];
    assign u_in  = s_axis_tdata[15:0];

    function automatic logic [15:0] clamp(input logic signed [50:0] s);
        logic signed [50:0] c;
        c = s >>> 17;
        if (s < 0)
            return 16'd0;
        else if (c > $signed({34'd0, GeneMax}))
            return GeneMax[15:0];
        else
            return c[15:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            eta_reg    <= EtaReset;
            beta_reg   <= BetaOne;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            beta_reg   <= beta_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid && cfg_ready)
                eta_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        last_reg  <= last_next;
        cnt_reg   <= cnt_next;
        phase_reg <= phase_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        m_reg     <= m_next;
        n_reg     <= n_next;
        frac_reg  <= frac_next;
        neg_reg   <= neg_next;
        ip_reg    <= ip_next;
        f_reg     <= f_next;
        p_reg     <= p_next;
        prod_reg  <= prod_next;
        dneg_reg  <= dneg_next;
        ca_reg    <= ca_next;
        cb_reg    <= cb_next;
        olast_reg <= olast_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        beta_next   = beta_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        last_next   = last_reg;
        cnt_next    = cnt_reg;
        phase_next  = phase_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        m_next      = m_reg;
        n_next      = n_reg;
        frac_next   = frac_reg;
        neg_next    = neg_reg;
        ip_next     = ip_reg;
        f_next      = f_reg;
        p_next      = p_reg;
        prod_next   = prod_reg;
        dneg_next   = dneg_reg;
        ca_next     = ca_reg;
        cb_next     = cb_reg;
        olast_next  = olast_reg;
        ovalid_next = ovalid_reg;
        mul_x       = '0;
        mul_y       = '0;
        lmag        = '0;
        eval        = '0;
        sh          = '0;
        shr         = '0;
        dsum        = '0;
        ddiff       = '0;
        dmag        = '0;
        base        = '0;
        spread      = '0;
        sa          = '0;
        sb          = '0;

        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    a_next    = s_axis_tdata[31:16];
                    b_next    = s_axis_tdata[47:32];
                    last_next = s_axis_tlast;
                    if (!s_axis_tuser)
                        state_next = ST_MUL;
                    else if (u_in == 16'd0)
                    begin
                        beta_next  = '0;
                        state_next = ST_MUL;
                    end
                    else if (u_in <= 16'd32768)
                    begin
                        m_next     = {15'd0, u_in, 1'b0};
                        n_next     = 5'd31;
                        state_next = ST_NORM;
                    end
                    else
                    begin
                        quo_next   = 32'h8000_0000;
                        rem_next   = '0;
                        dvs_next   = 16'd0 - u_in;
                        cnt_next   = 5'd31;
                        phase_next = 1'b0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = fits ? 16'(trial - {1'b0, dvs_reg}) : trial[15:0];
                quo_next = {quo_reg[30:0], fits};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    if (!phase_reg)
                    begin
                        m_next     = {quo_reg[30:0], fits};
                        n_next     = 5'd31;
                        state_next = ST_NORM;
                    end
                    else
                    begin
                        eval       = neg_reg ? 22'd0 - {1'b0, quo_reg[19:0], fits}
                                             : {1'b0, quo_reg[19:0], fits};
                        ip_next    = $signed(eval[21:16]);
                        f_next     = eval[15:0];
                        p_next     = 31'd1 << 30;
                        cnt_next   = 5'd15;
                        state_next = ST_EXPO;
                    end
                end
            end
            ST_NORM:
            begin
                if (m_reg[31])
                begin
                    cnt_next   = 5'd15;
                    frac_next  = '0;
                    state_next = ST_LOG;
                end
                else
                begin
                    m_next = {m_reg[30:0], 1'b0};
                    n_next = n_reg - 5'd1;
                end
            end
            ST_LOG:
            begin
                mul_x     = m_reg;
                mul_y     = m_reg;
                frac_next = {frac_reg[14:0], sq[32]};
                m_next    = sq[32] ? sq[32:1] : sq[31:0];
                cnt_next  = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                neg_next = !n_reg[4];
                if (!n_reg[4])
                    lmag = {5'd16 - n_reg, 16'd0} - {5'd0, frac_reg};
                else
                    lmag = {1'b0, n_reg[3:0], frac_reg};
                quo_next   = {3'd0, lmag, 8'd0};
                rem_next   = '0;
                dvs_next   = {1'b0, eta_reg} + 16'd256;
                cnt_next   = 5'd31;
                phase_next = 1'b1;
                state_next = ST_DIV;
            end
            ST_EXPO:
            begin
                mul_x = {1'b0, p_reg};
                mul_y = {1'b0, Roots[~cnt_reg[3:0]]};
                if (f_reg[cnt_reg[3:0]])
                    p_next = mul_p[60:30];
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                    state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (ip_reg <= 6'sd14)
                begin
                    sh  = 5'(6'sd14 - ip_reg);
                    shr = {1'b0, p_reg} >> sh;
                end
                else
                begin
                    shr = {p_reg, 1'b0};
                end
                beta_next  = shr;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                ddiff      = {1'b0, a_reg} - {1'b0, b_reg};
                dneg_next  = ddiff[16];
                dmag       = ddiff[16] ? 16'(17'd0 - ddiff) : ddiff[15:0];
                mul_x      = beta_reg;
                mul_y      = {16'd0, dmag};
                prod_next  = mul_p[47:0];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                dsum   = {1'b0, a_reg} + {1'b0, b_reg};
                base   = $signed({18'd0, dsum, 16'd0});
                spread = dneg_reg ? -$signed({3'd0, prod_reg}) : $signed({3'd0, prod_reg});
                sa     = base + spread;
                sb     = base - spread;
                if (!ovalid_reg || m_axis_tready)
                begin
                    ca_next     = clamp(sa);
                    cb_next     = clamp(sb);
                    olast_next  = last_reg;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {cb_reg, ca_reg};
    assign m_axis_tlast  = olast_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/sbx_checker.sv
// port checker for the crossover block, bound to the top level
// depends on simulated_binary_crossover_top_defines.svh
`default_nettype none

`include "simulated_binary_crossover_top_defines.svh"

module sbx_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    // a stalled result stays offered
    `SBX_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")

    // one pair in work at a time
    `SBX_ASSERT(a_busy, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while busy")

    // children stay within the clamp
    `SBX_ASSERT(a_clamp, m_axis_tvalid |-> m_axis_tdata[15:0] <= 16'd32768 && m_axis_tdata[31:16] <= 16'd32768, "child out of range")

    // nothing offered out of reset
    `SBX_ASSERT_ALWAYS(a_reset, !rst_n |-> !m_axis_tvalid, "result during reset")

endmodule

bind simulated_binary_crossover_top sbx_checker u_sbx_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
